[hw/rtl/first_free_slot_allocator_core_macros.svh]
// Assertion helpers used by the allocator core RTL.
`ifndef FIRST_FREE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check outside reset.
`define FFSA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check on every edge, reset included.
`define FFSA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FFSA_ASSERT(name, prop, msg)
`define FFSA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[hw/rtl/ffsa_pkg.sv]
package ffsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = MAX_SLOTS / WORD_W;
    localparam int WORD_AW   = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int SLOT_W    = 8;
    localparam int CNT_W     = 9;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_BEYOND       = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_WORK
    } fsm_t;

    // Position of the lowest set bit; zero when none is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[hw/rtl/ffsa_ram.sv]
module ffsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/first_free_slot_allocator_core.sv]
// Channel   Dir  Width  Contents (lowest bit first)
// s_*       in   16     kind[1:0], slot_index[9:2], zero pad
// m_*       out  24     status[1:0], granted_slot[9:2], occupied_count[18:10], zero pad
// cfg_*     in   9      slot_count
//
// Free and clear go through accept (map word read issued), then commit.
// Allocate scans the 64-slot map words in turn from word zero, then commits.
// The free map sits in a NUM_WORDS x 64 RAM; per-word valid flops stand in for
// its all-free reset, so reset and clear take effect at once, no clearing pass.
// A commit waits while the output word is still held by the sink; one request
// is in work at a time, and the next is accepted once the current one commits.
`include "first_free_slot_allocator_core_macros.svh"

module first_free_slot_allocator_core
    import ffsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // kind[1:0], slot_index[9:2]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[1:0], granted_slot[9:2], occupied_count[18:10]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data   // slot_count
);

    fsm_t                 state_reg, state_next;
    logic [1:0]           kind_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [WORD_AW-1:0]   word_reg, word_next;
    logic [NUM_WORDS-1:0] valid_reg;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     slot_count_reg;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic                 in_accept;
    logic [1:0]           s_kind;
    logic [SLOT_W-1:0]    s_idx;
    logic [CNT_W-1:0]     n_active;
    logic                 out_free;

    logic                 ram_we, ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;

    logic [WORD_W-1:0]    word_eff;
    logic [WORD_W-1:0]    avail;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic [WORD_AW:0]     word_inc;
    logic [CNT_W-1:0]     next_base;
    logic                 last_word;
    logic [BIT_W-1:0]     free_bit;
    logic                 beyond;

    logic                 out_load;
    status_t              out_status;
    logic [SLOT_W-1:0]    out_granted;
    logic                 clear_map;

    assign s_kind    = s_tdata[1:0];
    assign s_idx     = s_tdata[SLOT_W+1:2];
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Clamp the configured count to the pool size.
    assign n_active = (slot_count_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                           : slot_count_reg;

    ffsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A word never written since reset or clear reads as all free.
    assign word_eff = valid_reg[word_reg] ? ram_rdata : '1;

    // Free bits of this word that fall below the active slot count.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            avail[b] = word_eff[b] && (CNT_W'({word_reg, BIT_W'(b)}) < n_active);
        end
    end

    assign hit       = |avail;
    assign hit_bit   = lowest_set(avail);
    assign word_inc  = {1'b0, word_reg} + (WORD_AW+1)'(1);
    assign next_base = CNT_W'({word_inc, {BIT_W{1'b0}}});
    assign last_word = next_base >= n_active;
    assign free_bit  = idx_reg[BIT_W-1:0];
    assign beyond    = CNT_W'(idx_reg) >= n_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        word_next   = word_reg;
        used_next   = used_reg;
        s_tready    = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        ram_we      = 1'b0;
        ram_wdata   = word_eff;
        out_load    = 1'b0;
        out_status  = ST_OK;
        out_granted = '0;
        clear_map   = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (in_accept) begin
                    // Fetch the word holding the slot, or word zero to start a scan.
                    ram_re     = 1'b1;
                    ram_raddr  = (s_kind == K_FREE) ? s_idx[SLOT_W-1:BIT_W] : '0;
                    word_next  = ram_raddr;
                    state_next = FSM_WORK;
                end
            end
            FSM_WORK: begin
                unique case (kind_reg)
                    K_ALLOC: begin
                        if (!hit && !last_word) begin
                            // Advance to the next map word.
                            ram_re    = 1'b1;
                            ram_raddr = word_inc[WORD_AW-1:0];
                            word_next = word_inc[WORD_AW-1:0];
                        end else if (out_free) begin
                            out_load   = 1'b1;
                            state_next = FSM_IDLE;
                            if (hit) begin
                                ram_we      = 1'b1;
                                ram_wdata   = word_eff & ~(WORD_W'(1) << hit_bit);
                                out_granted = {word_reg, hit_bit};
                                if (used_reg != COUNT_MAX) begin
                                    used_next = used_reg + CNT_W'(1);
                                end
                            end else begin
                                out_status = ST_FULL;
                            end
                        end
                    end
                    K_FREE: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = FSM_IDLE;
                            if (beyond) begin
                                out_status = ST_BEYOND;
                            end else if (word_eff[free_bit] || used_reg == '0) begin
                                out_status = ST_ALREADY_FREE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = word_eff | (WORD_W'(1) << free_bit);
                                used_next = used_reg - CNT_W'(1);
                            end
                        end
                    end
                    K_CLEAR: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            clear_map  = 1'b1;
                            used_next  = '0;
                            state_next = FSM_IDLE;
                        end
                    end
                    default: begin
                        // Unused kind: answer ok, change nothing.
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = FSM_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            used_reg       <= '0;
            slot_count_reg <= CNT_W'(MAX_SLOTS);
            m_tvalid_reg   <= 1'b0;
        end else begin
            used_reg <= used_next;
            if (clear_map) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[word_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                slot_count_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the request and the result word.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (in_accept) begin
            kind_reg <= s_kind;
            idx_reg  <= s_idx;
        end
        if (out_load) begin
            m_tdata_reg <= OUT_W'({used_next, out_granted, out_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FFSA_ASSERT(a_count_bound, used_reg <= CNT_W'(MAX_SLOTS), "occupied count exceeds pool")
    `FFSA_ASSERT(a_grant_active, (state_reg == FSM_WORK && kind_reg == K_ALLOC && hit) |-> (CNT_W'({word_reg, hit_bit}) < n_active), "grant beyond slot count")
    `FFSA_ASSERT(a_rw_exclusive, !(ram_we && ram_re), "map read and write in the same cycle")
    `FFSA_ASSERT(a_result_from_work, $rose(m_tvalid_reg) |-> $past(state_reg == FSM_WORK), "result word without a request in work")
    `FFSA_ASSERT_ALWAYS(a_reset_drains, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule

[verif/first_free_slot_allocator_core_tb.sv]
module first_free_slot_allocator_core_tb;
    import ffsa_pkg::*;

    // Kind code that the block has no operation for; it must come back as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Settle time after the last word: worst allocate scan plus margin.
    localparam int SETTLE_CYCLES = NUM_WORDS + 4;

    // One response word, packed in the order it sits in m_tdata.
    typedef struct packed {
        logic [CNT_W-1:0]  occupied;
        logic [SLOT_W-1:0] granted;
        status_t           status;
    } grant_word_t;

    // Shadow of the slot pool: predicts each response and checks it on arrival.
    class slot_pool_scoreboard;
        bit [MAX_SLOTS-1:0] free_map;
        logic [CNT_W-1:0]   used_total;
        logic [CNT_W-1:0]   slot_count;
        grant_word_t        expected_q[$];
        int                 mismatches;

        function new();
            free_map   = '1;
            used_total = '0;
            slot_count = CNT_W'(256);
            mismatches = 0;
        endfunction

        function int active_slots();
            return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
        endfunction

        function void set_slot_count(logic [CNT_W-1:0] value);
            slot_count = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Pick an occupied slot inside the active range, -1 if there is none.
        function int pick_used_slot();
            int n;
            int start;
            int s;
            n = active_slots();
            if (n == 0) return -1;
            start = $urandom_range(n - 1);
            for (int k = 0; k < n; k++) begin
                s = (start + k) % n;
                if (!free_map[s]) return s;
            end
            return -1;
        endfunction

        // Apply one accepted request to the shadow pool and queue its response.
        function void note_request(logic [1:0] kind, logic [SLOT_W-1:0] idx);
            grant_word_t r;
            int          n;
            bit          found;
            n        = active_slots();
            found    = 1'b0;
            r.status = ST_OK;
            r.granted = '0;
            case (kind)
                K_ALLOC: begin
                    for (int i = 0; i < n; i++) begin
                        if (!found && free_map[i]) begin
                            free_map[i] = 1'b0;
                            r.granted   = SLOT_W'(i);
                            found       = 1'b1;
                            if (used_total != COUNT_MAX) used_total++;
                        end
                    end
                    if (!found) r.status = ST_FULL;
                end
                K_FREE: begin
                    if (int'(idx) >= n) begin
                        r.status = ST_BEYOND;
                    end else if (free_map[idx] || used_total == 0) begin
                        r.status = ST_ALREADY_FREE;
                    end else begin
                        free_map[idx] = 1'b1;
                        used_total--;
                    end
                end
                K_CLEAR: begin
                    free_map   = '1;
                    used_total = '0;
                end
                default: ;
            endcase
            r.occupied = used_total;
            expected_q.push_back(r);
        endfunction

        function void report(string what, int exp_val, int act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s expected %0d got %0d", what, exp_val, act_val);
        endfunction

        // Compare one accepted response word against the oldest prediction.
        function void check_result(logic [OUT_W-1:0] word);
            grant_word_t exp_word;
            grant_word_t act_word;
            act_word = word[$bits(grant_word_t)-1:0];
            if (expected_q.size() == 0) begin
                report("unexpected word, status", -1, int'(act_word.status));
                return;
            end
            exp_word = expected_q.pop_front();
            if (act_word.status !== exp_word.status)
                report("status", int'(exp_word.status), int'(act_word.status));
            if (act_word.granted !== exp_word.granted)
                report("granted_slot", int'(exp_word.granted), int'(act_word.granted));
            if (act_word.occupied !== exp_word.occupied)
                report("occupied_count", int'(exp_word.occupied), int'(act_word.occupied));
            if (word[OUT_W-1:$bits(grant_word_t)] !== '0)
                report("pad bits", 0, int'(word[OUT_W-1:$bits(grant_word_t)]));
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;   // kind[1:0], slot_index[9:2]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // status[1:0], granted_slot[9:2], occupied_count[18:10]
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;   // slot_count

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    slot_pool_scoreboard sb = new();

    // Slot counts per random segment: zero, one, word edges, above the pool size.
    int seg_slot_counts[18] = '{4, 64, 256, 1, 65, 0,
                                2, 511, 63, 128, 300, 17,
                                256, 5, 66, 200, 130, 1};

    first_free_slot_allocator_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the response side at random; a zero percentage keeps m_tready high.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watch every handshake: feed the shadow pool, check responses.
    // Register writes come first, though they never share an edge with requests.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_slot_count(cfg_data);
            if (s_tvalid && s_tready) sb.note_request(s_tdata[1:0], s_tdata[SLOT_W+1:2]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Hang detector: count edges where no word moves on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request word; hold it until the block takes it.
    // Valid stays high into the next word unless a gap is drawn.
    task automatic send_request(input logic [1:0] kind, input logic [SLOT_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - SLOT_W - 2){1'b0}}, idx, kind};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off new requests until every predicted word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        // Let the monitor log a word accepted at this very edge first.
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slot_count(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Draw one request: mostly allocate/free of live slots, some clears and stray kinds.
    task automatic send_random_request(input int alloc_pct, input int clear_pct);
        int               r;
        int               pick;
        logic [1:0]       kind;
        logic [SLOT_W-1:0] idx;
        r    = $urandom_range(99);
        idx  = SLOT_W'($urandom_range(255));
        pick = -1;
        if (r < alloc_pct) begin
            kind = K_ALLOC;
        end else if (r < 99 - clear_pct) begin
            kind = K_FREE;
            // Aim most frees at live slots; the rest use a random index: free, live or out of range.
            if ($urandom_range(9) < 8) pick = sb.pick_used_slot();
            if (pick >= 0) idx = SLOT_W'(pick);
        end else if (r < 99) begin
            kind = K_CLEAR;
        end else begin
            kind = KIND_UNUSED;
        end
        send_request(kind, idx);
    endtask

    initial begin
        int cnt;
        bit big;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 45;

        // Small pool: fill it, overflow, free twice, free out of range.
        write_slot_count(4);
        repeat (4) send_request(K_ALLOC, 8'h00);
        send_request(K_ALLOC, 8'hFF);
        send_request(K_FREE, 8'd2);
        send_request(K_FREE, 8'd2);
        send_request(K_FREE, 8'd4);
        send_request(K_FREE, 8'hFF);
        send_request(K_ALLOC, 8'h00);
        send_request(KIND_UNUSED, 8'hFF);
        send_request(K_CLEAR, 8'hFF);
        send_request(K_ALLOC, 8'h00);
        send_request(K_FREE, 8'd0);
        // Count is back at zero here.
        send_request(K_FREE, 8'd0);
        drain_results();

        // Empty pool: allocate is full, any free is out of range.
        write_slot_count(0);
        send_request(K_ALLOC, 8'h00);
        send_request(K_FREE, 8'd0);
        drain_results();

        // Count above the pool size clamps to the full pool.
        write_slot_count(511);
        send_request(K_ALLOC, 8'h00);
        send_request(K_FREE, 8'hFF);
        drain_results();

        // Single slot, already taken from the previous setting.
        write_slot_count(1);
        send_request(K_ALLOC, 8'h00);
        send_request(K_FREE, 8'd0);
        send_request(K_ALLOC, 8'h00);

        // Random segments under three idle patterns; large pools run long
        // enough with heavy allocation to reach the full state.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 45 : 0;
            recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 30 : 0;
            for (int seg = 0; seg < 6; seg++) begin
                cnt = seg_slot_counts[mode * 6 + seg];
                big = (cnt >= MAX_SLOTS);
                drain_results();
                write_slot_count(cnt);
                repeat (big ? 320 : 40) send_random_request(big ? 94 : 55, big ? 0 : 2);
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/first_free_slot_allocator_core.sv
verif/first_free_slot_allocator_core_tb.sv
